// ===== sv/ifs_pkg.sv =====
`default_nettype none
package ifs_pkg;

	// Longest burst caused by one payload byte: header, stuffed byte, stuffed parity, flag
	localparam int unsigned MAX_RESULTS = 9;
	localparam int unsigned CNT_W       = 4;

	localparam logic [7:0] STUFF_XOR   = 8'h20;
	localparam logic [7:0] FLAG_RESET  = 8'h7E;
	localparam logic [7:0] ESC_RESET   = 8'h7D;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_FLAG   = 1'b0,
		REG_ESCAPE = 1'b1
	} ifs_reg_t;

	// One stuffed byte: low byte goes out first
	typedef struct packed {
		logic        two;
		logic [15:0] pair;
	} ifs_stuffed_t;

	// Line bytes produced by one input item, byte 0 first
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [CNT_W-1:0]            count;
		logic                        closes;
	} ifs_job_t;

	function automatic ifs_stuffed_t stuff(input logic [7:0] b, input logic [7:0] flag,
		input logic [7:0] esc);
		ifs_stuffed_t r;
		if (b == flag || b == esc) begin
			r.two  = 1'b1;
			r.pair = {b ^ STUFF_XOR, esc};
		end else begin
			r.two  = 1'b0;
			r.pair = {8'h00, b};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/ifs_in_if.sv =====
`default_nettype none
interface ifs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;
	logic [7:0] address;
	logic [7:0] control;

	modport source (output valid, data_byte, first_byte, last_byte, address, control,
		input ready);
	modport sink (input valid, data_byte, first_byte, last_byte, address, control,
		output ready);
endinterface
`default_nettype wire

// ===== sv/ifs_out_if.sv =====
`default_nettype none
interface ifs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       run_last;

	modport source (output valid, out_byte, frame_end, run_last, input ready);
	modport sink (input valid, out_byte, frame_end, run_last, output ready);
endinterface
`default_nettype wire

// ===== sv/ifs_build.sv =====
`default_nettype none
module ifs_build (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire logic [7:0]       data_byte,
	input  wire logic             first_byte,
	input  wire logic             last_byte,
	input  wire logic [7:0]       address,
	input  wire logic [7:0]       control,
	input  wire logic [7:0]       flag,
	input  wire logic [7:0]       esc,
	output ifs_pkg::ifs_job_t     job
);
	import ifs_pkg::*;

	localparam int unsigned VEC_W = MAX_RESULTS * 8;

	logic [7:0]       parity_q;
	logic [7:0]       parity_next;
	ifs_stuffed_t     d_st;
	ifs_stuffed_t     p_st;
	logic [31:0]      hdr;
	logic [23:0]      tail;
	logic [CNT_W-1:0] pos_data;
	logic [CNT_W-1:0] pos_tail;
	logic [CNT_W-1:0] tail_n;
	logic [VEC_W-1:0] vec;

	// Restart parity on the first byte, otherwise fold the byte in
	assign parity_next = first_byte ? data_byte : (parity_q ^ data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= '0;
		end else if (take) begin
			parity_q <= parity_next;
		end
	end

	// Lay out header, stuffed byte and closing tail back to back
	always_comb begin
		d_st     = stuff(data_byte, flag, esc);
		p_st     = stuff(parity_next, flag, esc);
		hdr      = first_byte ? {address ^ control, control, address, flag} : 32'h0;
		pos_data = first_byte ? CNT_W'(4) : CNT_W'(0);
		pos_tail = pos_data + (d_st.two ? CNT_W'(2) : CNT_W'(1));
		if (!last_byte) begin
			tail   = 24'h0;
			tail_n = '0;
		end else if (p_st.two) begin
			tail   = {flag, p_st.pair};
			tail_n = CNT_W'(3);
		end else begin
			tail   = {8'h00, flag, p_st.pair[7:0]};
			tail_n = CNT_W'(2);
		end
		vec = VEC_W'(hdr)
			| (VEC_W'(d_st.pair) << {pos_data, 3'b000})
			| (VEC_W'(tail) << {pos_tail, 3'b000});
		job.bytes  = vec;
		job.count  = pos_tail + tail_n;
		job.closes = last_byte;
	end

endmodule
`default_nettype wire

// ===== sv/ifs_emit.sv =====
`default_nettype none
module ifs_emit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire ifs_pkg::ifs_job_t job_in,
	output logic                   take_ok,
	output logic                   busy,
	ifs_out_if.source              egress
);
	import ifs_pkg::*;

	ifs_job_t         job_s1;
	logic             job_vld_q;
	logic [CNT_W-1:0] idx_q;
	logic             out_vld_q;
	logic [7:0]       out_byte_q;
	logic             frame_end_q;
	logic             run_last_q;
	logic             adv;
	logic             at_end;

	// Move one byte into the output register when it is free or being drained
	assign adv     = job_vld_q && (!out_vld_q || egress.ready);
	assign at_end  = (idx_q == job_s1.count - CNT_W'(1));
	assign take_ok = !job_vld_q || (adv && at_end);
	assign busy    = job_vld_q;

	// Hold the burst and step through it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (load) begin
			job_vld_q <= 1'b1;
			idx_q     <= '0;
		end else if (adv && at_end) begin
			job_vld_q <= 1'b0;
		end else if (adv) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= job_in;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (egress.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q  <= job_s1.bytes[idx_q];
			run_last_q  <= at_end;
			frame_end_q <= at_end && job_s1.closes;
		end
	end

	assign egress.valid     = out_vld_q;
	assign egress.out_byte  = out_byte_q;
	assign egress.frame_end = frame_end_q;
	assign egress.run_last  = run_last_q;

endmodule
`default_nettype wire

// ===== sv/information_frame_stuffer.sv =====
// Information frame stuffer: turns payload bytes into an HDLC-style stuffed line stream.
// ingress carries one payload byte per transfer with first/last marks and, on the first
// byte, the address and control fields. egress carries one line byte per transfer;
// run_last marks the final byte caused by an input, frame_end marks the closing flag.
// Each accepted byte is expanded into a burst of 1 to 9 line bytes (4 header bytes on a
// first byte, 1 or 2 for the stuffed byte, 0, 2 or 3 for stuffed parity and flag).
// Each accepted item is registered in the burst register, and each of its line bytes then passes
// through the output register to egress. Throughput: one line byte per cycle from the output
// register while egress is ready.
// The next input is taken in the cycle the last byte of the current burst moves to the
// output register, so bursts follow each other without gaps.
// When egress stalls, the output register holds its byte and the burst waits; ingress
// ready stays low until the last byte of the burst moves to the output register.
// Reset clears both channels, sets flag to 0x7E, escape to 0x7D and the parity to zero.
// Write the configuration registers only while no burst is pending.
`default_nettype none
module information_frame_stuffer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	ifs_in_if.sink          ingress,
	ifs_out_if.source       egress
);
	import ifs_pkg::*;

	logic [7:0] flag_q;
	logic [7:0] escape_q;
	logic       take;
	logic       take_ok;
	logic       busy;
	ifs_job_t   job;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q   <= FLAG_RESET;
			escape_q <= ESC_RESET;
		end else if (cfg_we) begin
			unique case (ifs_reg_t'(cfg_index))
				REG_FLAG:   flag_q   <= cfg_data;
				REG_ESCAPE: escape_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ingress.ready = take_ok;
	assign take          = ingress.valid && take_ok;

	ifs_build u_build (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (ingress.data_byte),
		.first_byte (ingress.first_byte),
		.last_byte  (ingress.last_byte),
		.address    (ingress.address),
		.control    (ingress.control),
		.flag       (flag_q),
		.esc        (escape_q),
		.job        (job)
	);

	ifs_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (take),
		.job_in  (job),
		.take_ok (take_ok),
		.busy    (busy),
		.egress  (egress)
	);

	// A closing flag always ends its burst
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		egress.valid && egress.frame_end |-> egress.run_last)
		else $error("closing flag not marked as last byte of its burst");

	// A transfer leaves a burst pending
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy)
		else $error("accepted item left no burst");

	// Burst length stays within one to nine bytes
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (job.count != '0 && job.count <= CNT_W'(MAX_RESULTS)))
		else $error("burst length out of range");

	// With nothing pending the input side is open
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ingress.ready)
		else $error("input stalled with no burst pending");

endmodule
`default_nettype wire

// ===== verif/tb_information_frame_stuffer.sv =====
`timescale 1ns / 1ps

import ifs_pkg::*;

// One line byte as seen on egress
typedef struct packed {
	logic [7:0] out_byte;
	logic       frame_end;
	logic       run_last;
} line_byte_t;

// Predict the stuffed line stream and hold the bytes still owed by the block
class line_stream_model;
	logic [7:0]   flag_val;
	logic [7:0]   esc_val;
	logic [7:0]   parity;
	line_byte_t   due[$];
	int unsigned  mismatches;

	function new();
		flag_val   = FLAG_RESET;
		esc_val    = ESC_RESET;
		parity     = 8'h00;
		mismatches = 0;
	endfunction

	function void write_reg(ifs_reg_t idx, logic [7:0] value);
		case (idx)
			REG_FLAG:   flag_val = value;
			REG_ESCAPE: esc_val  = value;
			default: ;
		endcase
	endfunction

	function void push_byte(logic [7:0] b, logic fe);
		line_byte_t lb;
		lb.out_byte  = b;
		lb.frame_end = fe;
		lb.run_last  = 1'b0;
		due.push_back(lb);
	endfunction

	// Escape the flag and escape values, a value equal to both only once
	function void push_stuffed(logic [7:0] b);
		if (b == flag_val || b == esc_val) begin
			push_byte(esc_val, 1'b0);
			push_byte(b ^ 8'h20, 1'b0);
		end else begin
			push_byte(b, 1'b0);
		end
	endfunction

	// Note an accepted payload byte and queue the line bytes it causes
	function void take_payload(logic [7:0] data, logic first, logic last,
		logic [7:0] addr, logic [7:0] ctrl);
		line_byte_t tail;
		if (first) begin
			push_byte(flag_val, 1'b0);
			push_byte(addr, 1'b0);
			push_byte(ctrl, 1'b0);
			push_byte(addr ^ ctrl, 1'b0);
			parity = data;
		end else begin
			parity = parity ^ data;
		end
		push_stuffed(data);
		if (last) begin
			push_stuffed(parity);
			push_byte(flag_val, 1'b1);
		end
		// mark the end of this burst
		tail = due.pop_back();
		tail.run_last = 1'b1;
		due.push_back(tail);
	endfunction

	// Compare one egress transfer against the oldest owed byte
	function void match_line_byte(logic [7:0] b, logic fe, logic rl);
		line_byte_t want;
		if (due.size() == 0) begin
			$error("unexpected line byte %h (frame_end %b, run_last %b)", b, fe, rl);
			mismatches++;
			return;
		end
		want = due.pop_front();
		if (b !== want.out_byte) begin
			$error("out_byte: expected %h, actual %h", want.out_byte, b);
			mismatches++;
		end
		if (fe !== want.frame_end) begin
			$error("frame_end: expected %b, actual %b", want.frame_end, fe);
			mismatches++;
		end
		if (rl !== want.run_last) begin
			$error("run_last: expected %b, actual %b", want.run_last, rl);
			mismatches++;
		end
	endfunction
endclass

module tb_information_frame_stuffer;

	localparam int unsigned CYCLE_LIMIT = 300000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;
	bit         calm;
	int unsigned cycle_count;
	line_stream_model model;

	ifs_in_if  in_ch ();
	ifs_out_if out_ch ();

	information_frame_stuffer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ingress   (in_ch),
		.egress    (out_ch)
	);

	always #1 clk = ~clk;

	// Offer one payload byte and hold it until the transfer
	task automatic send_payload(logic [7:0] data, logic first, logic last,
		logic [7:0] addr, logic [7:0] ctrl);
		while (!calm && $urandom_range(0, 99) < 16) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.data_byte  <= data;
		in_ch.first_byte <= first;
		in_ch.last_byte  <= last;
		in_ch.address    <= addr;
		in_ch.control    <= ctrl;
		do @(posedge clk); while (!in_ch.ready);
		model.take_payload(data, first, last, addr, ctrl);
	endtask

	// Drop valid and wait until every owed line byte has arrived
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (model.due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Write both registers back to back; call only while idle
	task automatic write_config(logic [7:0] flag_v, logic [7:0] esc_v);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FLAG;
		cfg_data  <= flag_v;
		@(posedge clk);
		model.write_reg(REG_FLAG, flag_v);
		cfg_index <= REG_ESCAPE;
		cfg_data  <= esc_v;
		@(posedge clk);
		model.write_reg(REG_ESCAPE, esc_v);
		cfg_we <= 1'b0;
	endtask

	// Bias payload toward values that need stuffing, and steer the parity onto them
	function automatic logic [7:0] pick_payload(bit first, bit last);
		int unsigned roll;
		logic [7:0]  target;
		roll   = $urandom_range(0, 99);
		target = ($urandom_range(0, 1) != 0) ? model.flag_val : model.esc_val;
		if (last && roll < 25)
			return first ? target : (model.parity ^ target);
		if (roll < 45)
			return target;
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly well-formed frames with random content, some loose bytes
	task automatic run_random(int unsigned count);
		int unsigned sent;
		int unsigned len;
		bit          paused;
		logic [7:0]  addr;
		logic [7:0]  ctrl;
		sent   = 0;
		paused = 1'b0;
		while (sent < count) begin
			addr = 8'($urandom_range(0, 255));
			ctrl = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 9) == 0) begin
				send_payload(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), addr, ctrl);
				sent++;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
					: $urandom_range(1, 6);
				for (int unsigned i = 0; i < len; i++)
					send_payload(pick_payload(i == 0, i == len - 1), i == 0, i == len - 1,
						addr, ctrl);
				sent += len;
			end
			// hold off the sender once until the block has drained
			if (!paused && sent >= count / 2) begin
				paused = 1'b1;
				settle();
			end
		end
	endtask

	// Sample egress and stall it at random
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				model.match_line_byte(out_ch.out_byte, out_ch.frame_end, out_ch.run_last);
			out_ch.ready <= arst_n && (calm || $urandom_range(0, 99) >= 16);
		end
	end

	// Stop a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** information_frame_stuffer: FAILED **");
		$finish;
	end

	initial begin
		model = new();
		calm  = 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.data_byte  <= 8'h00;
		in_ch.first_byte <= 1'b0;
		in_ch.last_byte  <= 1'b0;
		in_ch.address    <= 8'h00;
		in_ch.control    <= 8'h00;
		cfg_we    <= 1'b0;
		cfg_index <= REG_FLAG;
		cfg_data  <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: one-byte frame, all-ones header, both stuffed values
		send_payload(8'h00, 1'b1, 1'b1, 8'h00, 8'h00);
		send_payload(8'hFF, 1'b1, 1'b0, 8'hFF, 8'hFF);
		send_payload(8'h7E, 1'b0, 1'b0, 8'h00, 8'h00);
		send_payload(8'h7D, 1'b0, 1'b0, 8'h00, 8'h00);
		send_payload(8'h5E, 1'b0, 1'b0, 8'h00, 8'h00);
		send_payload(8'h5D, 1'b0, 1'b0, 8'h00, 8'h00);
		// parity lands on the flag value
		send_payload(8'h81, 1'b0, 1'b1, 8'h00, 8'h00);
		// header bytes equal to flag and escape go out unstuffed
		send_payload(8'h7D, 1'b1, 1'b0, 8'h7E, 8'h7D);
		send_payload(8'h00, 1'b0, 1'b1, 8'h00, 8'h00);
		// new frame while one is still open
		send_payload(8'h11, 1'b1, 1'b0, 8'h12, 8'h34);
		send_payload(8'h22, 1'b1, 1'b1, 8'h56, 8'h78);
		// bytes outside any frame keep the old parity going
		send_payload(8'h7E, 1'b0, 1'b0, 8'hAA, 8'h55);
		send_payload(8'h33, 1'b0, 1'b1, 8'h55, 8'hAA);
		send_payload(8'h7E, 1'b1, 1'b1, 8'h7E, 8'h7E);

		// flag equal to escape
		settle();
		write_config(8'h00, 8'h00);
		send_payload(8'h00, 1'b1, 1'b1, 8'h00, 8'h00);
		send_payload(8'h20, 1'b1, 1'b0, 8'hA5, 8'h5A);
		send_payload(8'hFF, 1'b0, 1'b1, 8'h00, 8'h00);

		settle();
		write_config(8'hFF, 8'h00);
		send_payload(8'hFF, 1'b1, 1'b0, 8'h3C, 8'hC3);
		send_payload(8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
		send_payload(8'hFF, 1'b0, 1'b1, 8'h00, 8'h00);

		// random phases over several register settings
		settle();
		write_config(FLAG_RESET, ESC_RESET);
		run_random(110);

		settle();
		write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		calm = 1'b1;
		run_random(100);
		calm = 1'b0;

		settle();
		write_config(8'h00, 8'hFF);
		run_random(100);

		settle();
		begin
			logic [7:0] same;
			same = 8'($urandom_range(0, 255));
			write_config(same, same);
		end
		run_random(110);

		settle();
		repeat (16) @(posedge clk);
		if (model.mismatches == 0 && model.due.size() == 0) begin
			$display("** information_frame_stuffer: PASSED **");
		end else begin
			$display("** information_frame_stuffer: FAILED **");
		end
		$finish;
	end

endmodule
